[design/line_plane_intersection_macros.svh]
// ---------------------------------------------------------------------------
// Line-plane intersection assertion macros
// Concurrent assertion shorthands; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef LINE_PLANE_INTERSECTION_MACROS_SVH
`define LINE_PLANE_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
`define LPI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_plane_intersection: assertion failed");
`define LPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_plane_intersection: assertion failed");
`else
`define LPI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/lpi_pkg.sv]
// ---------------------------------------------------------------------------
// Line-plane intersection package
// Shared constants and the side-band record carried down the pipeline.
// ---------------------------------------------------------------------------
package lpi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW            = 32;   // coordinate width
  localparam int DW            = 33;   // difference width

  localparam logic [CW-1:0] T_POS_LIMIT = 32'h7fff_ffff;
  localparam logic [CW-1:0] T_NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [2:0][CW-1:0] s;     // segment start
    logic [2:0][DW-1:0] d;     // end - start
    logic               tneg;  // sign of t
    logic               par;   // zero denominator
  } side_t;

endpackage

[design/line_plane_intersection.sv]
// ---------------------------------------------------------------------------
// Line-plane intersection
// Fixed-point intersection of a segment's line with a plane, fully pipelined.
// ---------------------------------------------------------------------------
// Accepts one item per clock while not stalled and returns one result per
// item, in order, through QW + 9 stages: four stages form the exact dot
// products, one prepares the divide, 32 restoring-divider stages produce one
// quotient bit each, and four stages clamp t, scale, round and saturate. The
// whole pipeline advances together; it stalls only while the output register
// holds a result that has not been taken.
`include "line_plane_intersection_macros.svh"

module line_plane_intersection #(
  parameter int FRAC_BITS = lpi_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_plane_px,
  input  logic [31:0] in_plane_py,
  input  logic [31:0] in_plane_pz,
  input  logic [31:0] in_normal_x,
  input  logic [31:0] in_normal_y,
  input  logic [31:0] in_normal_z,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_start_z,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  input  logic [31:0] in_end_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hit_x,
  output logic [31:0] out_hit_y,
  output logic [31:0] out_hit_z,
  output logic        out_parallel,
  output logic        out_saturated
);

  localparam int CW  = lpi_pkg::CW;
  localparam int DW  = lpi_pkg::DW;
  localparam int PW  = CW + DW;          // product width
  localparam int NW  = PW + 2;           // dot product width
  localparam int QW  = CW;               // quotient bits
  localparam int NSH = NW + FRAC_BITS;   // shifted numerator width
  localparam int HW  = NSH - QW;         // numerator bits above the quotient
  localparam int SW  = PW + 1;           // final sum width

  localparam int ST_DIV = 4;
  localparam int ST_TM  = ST_DIV + QW + 1;
  localparam int ST_PR  = ST_TM + 1;
  localparam int ST_RD  = ST_PR + 1;
  localparam int NST    = ST_RD + 2;

  logic adv;
  logic [NST-1:0] v_r;

  assign adv      = out_ready || !v_r[NST-1];
  // hold off transfers while reset is applied
  assign in_ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // stage 1: differences
  logic [2:0][CW-1:0] ip, inn, is, ie;
  assign ip  = {in_plane_pz, in_plane_py, in_plane_px};
  assign inn = {in_normal_z, in_normal_y, in_normal_x};
  assign is  = {in_start_z, in_start_y, in_start_x};
  assign ie  = {in_end_z, in_end_y, in_end_x};

  logic signed [DW-1:0] w1_r [3];
  logic signed [CW-1:0] n1_r [3];
  lpi_pkg::side_t c1_r, c2_r, c3_r, c4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        w1_r[i]   <= $signed({ip[i][CW-1], ip[i]}) - $signed({is[i][CW-1], is[i]});
        c1_r.d[i] <= {ie[i][CW-1], ie[i]} - {is[i][CW-1], is[i]};
        n1_r[i]   <= $signed(inn[i]);
      end
      c1_r.s    <= is;
      c1_r.tneg <= 1'b0;
      c1_r.par  <= 1'b0;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] pn2_r [3];
  logic signed [PW-1:0] pd2_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pn2_r[i] <= n1_r[i] * w1_r[i];
        pd2_r[i] <= n1_r[i] * $signed(c1_r.d[i]);
      end
      c2_r <= c1_r;
    end
  end

  // stage 3: sums
  logic signed [NW-1:0] num3_r, den3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      num3_r <= NW'(pn2_r[0]) + NW'(pn2_r[1]) + NW'(pn2_r[2]);
      den3_r <= NW'(pd2_r[0]) + NW'(pd2_r[1]) + NW'(pd2_r[2]);
      c3_r   <= c2_r;
    end
  end

  // stage 4: magnitudes and signs
  logic [NW-1:0] nmag4_r, dmag4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag4_r   <= num3_r[NW-1] ? NW'(-num3_r) : NW'(num3_r);
      dmag4_r   <= den3_r[NW-1] ? NW'(-den3_r) : NW'(den3_r);
      c4_r.s    <= c3_r.s;
      c4_r.d    <= c3_r.d;
      c4_r.tneg <= num3_r[NW-1] ^ den3_r[NW-1];
      c4_r.par  <= (den3_r == '0);
    end
  end

  // divider: entry k holds the partial result after k quotient bits
  logic [NW-1:0]  rem_r  [QW+1];
  logic [QW-1:0]  nlo_r  [QW+1];
  logic [QW-1:0]  q_r    [QW+1];
  logic [NW-1:0]  dmag_r [QW+1];
  logic           ovf_r  [QW+1];
  lpi_pkg::side_t cd_r   [QW+1];

  logic [NSH-1:0] nsh;
  assign nsh = {nmag4_r, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= {{(NW-HW){1'b0}}, nsh[NSH-1:QW]};
      nlo_r[0]  <= nsh[QW-1:0];
      q_r[0]    <= '0;
      dmag_r[0] <= dmag4_r;
      // quotient needs more than QW bits: flag now, t is clamped later
      ovf_r[0]  <= ({{(NW-HW){1'b0}}, nsh[NSH-1:QW]} >= dmag4_r);
      cd_r[0]   <= c4_r;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW:0] trial, diff;
    logic        ge;
    assign trial = {rem_r[k], nlo_r[k][QW-1]};
    assign diff  = trial - {1'b0, dmag_r[k]};
    assign ge    = (trial >= {1'b0, dmag_r[k]});

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= ge ? diff[NW-1:0] : trial[NW-1:0];
        nlo_r[k+1]  <= {nlo_r[k][QW-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][QW-2:0], ge};
        dmag_r[k+1] <= dmag_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        cd_r[k+1]   <= cd_r[k];
      end
    end
  end

  // clamp t
  logic [QW-1:0]  tm_r;
  logic           sat_tm_r;
  lpi_pkg::side_t ctm_r;
  logic [QW-1:0]  limit;
  assign limit = cd_r[QW].tneg ? lpi_pkg::T_NEG_LIMIT : lpi_pkg::T_POS_LIMIT;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ovf_r[QW] || q_r[QW] > limit) begin
        tm_r     <= limit;
        sat_tm_r <= 1'b1;
      end else begin
        tm_r     <= q_r[QW];
        sat_tm_r <= 1'b0;
      end
      ctm_r <= cd_r[QW];
    end
  end

  // scale offsets
  logic [PW-1:0]  prod_r [3];
  logic [2:0]     neg_pr_r;
  logic           sat_pr_r;
  lpi_pkg::side_t cpr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= (ctm_r.d[i][DW-1] ? DW'(-ctm_r.d[i]) : ctm_r.d[i]) * tm_r;
        neg_pr_r[i] <= ctm_r.d[i][DW-1] ^ ctm_r.tneg;
      end
      sat_pr_r <= sat_tm_r;
      cpr_r    <= ctm_r;
    end
  end

  // round to nearest, ties away from zero
  logic signed [SW-1:0] off_r [3];
  logic                 sat_rd_r;
  lpi_pkg::side_t       crd_r;
  logic [PW-1:0]        rm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rm[i] = (prod_r[i] + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        off_r[i] <= neg_pr_r[i] ? -$signed({1'b0, rm[i]}) : $signed({1'b0, rm[i]});
      end
      sat_rd_r <= sat_pr_r;
      crd_r    <= cpr_r;
    end
  end

  // add start point, saturate
  logic signed [SW-1:0] sum [3];
  logic [2:0][CW-1:0]   hit;
  logic [2:0]           clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SW'($signed(crd_r.s[i])) + off_r[i];
      clip[i] = 1'b1;
      if (sum[i] > SW'($signed(lpi_pkg::T_POS_LIMIT))) begin
        hit[i] = lpi_pkg::T_POS_LIMIT;
      end else if (sum[i] < -SW'($signed({1'b0, lpi_pkg::T_NEG_LIMIT}))) begin
        hit[i] = lpi_pkg::T_NEG_LIMIT;
      end else begin
        hit[i]  = sum[i][CW-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  logic [CW-1:0] hx_r, hy_r, hz_r;
  logic          par_r, sat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      par_r <= crd_r.par;
      if (crd_r.par) begin
        hx_r  <= crd_r.s[0];
        hy_r  <= crd_r.s[1];
        hz_r  <= crd_r.s[2];
        sat_r <= 1'b0;
      end else begin
        hx_r  <= hit[0];
        hy_r  <= hit[1];
        hz_r  <= hit[2];
        sat_r <= sat_rd_r || (clip != '0);
      end
    end
  end

  assign out_valid     = v_r[NST-1];
  assign out_hit_x     = hx_r;
  assign out_hit_y     = hy_r;
  assign out_hit_z     = hz_r;
  assign out_parallel  = par_r;
  assign out_saturated = sat_r;

  `LPI_ASSERT_SAME(a_par_no_sat, clk, rst_n, out_valid && out_parallel, !out_saturated)
  `LPI_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(v_r))
  `LPI_ASSERT_SAME(a_t_bound, clk, rst_n, v_r[ST_TM], tm_r <= lpi_pkg::T_NEG_LIMIT)

endmodule
